[sv/pfxs_pkg.sv]
package pfxs_pkg;

   // Screen geometry
   localparam int SCREEN_COLUMNS = 128;
   localparam int SCREEN_PAGES   = 8;
   localparam int SCREEN_ROWS    = SCREEN_PAGES * 8;
   localparam int STORE_BYTES    = SCREEN_COLUMNS * SCREEN_PAGES;
   localparam int SCROLL_COLS    = 4;

   localparam int COL_W  = $clog2(SCREEN_COLUMNS);
   localparam int PAGE_W = $clog2(SCREEN_PAGES);
   localparam int ROW_W  = PAGE_W + 3;
   localparam int ADDR_W = $clog2(STORE_BYTES);

   // Field widths
   localparam int ACTION_W = 3;
   localparam int COORD_W  = 8;
   localparam int SROWS_W  = 6;
   localparam int RADDR_W  = 10;
   localparam int MODE_W   = 2;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_DRAW   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DOWN   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_LEFT   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RIGHT  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd5;

   // Render modes
   localparam logic [MODE_W-1:0] MODE_LORES = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HIRES = 2'd1;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [COORD_W-1:0]  pixel_x;
      logic [COORD_W-1:0]  pixel_y;
      logic                draw_value;
      logic [SROWS_W-1:0]  scroll_rows;
      logic [RADDR_W-1:0]  read_address;
   } pfxs_req_type;

   typedef struct packed {
      logic       collision;
      logic [7:0] read_data;
   } pfxs_rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } pfxs_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAW_RD,
      ST_DRAW_WR,
      ST_DRAW_WR2,
      ST_READ,
      ST_READ_DATA,
      ST_DONE
   } pfxs_state_type;

   typedef enum logic [1:0] {
      SW_CLEAR,
      SW_DOWN,
      SW_LEFT,
      SW_RIGHT
   } pfxs_sweep_type;

   // Byte index of a page and column
   function automatic logic [ADDR_W-1:0] frame_addr(input logic [PAGE_W-1:0] page,
                                                    input logic [COL_W-1:0]  col);
      logic [31:0] t;
      t = 32'(page) * 32'(SCREEN_COLUMNS) + 32'(col);
      return t[ADDR_W-1:0];
   endfunction

   // Reduce a value below 512 modulo m (m at least 32) by compare and subtract
   function automatic logic [8:0] wrap_coord(input logic [8:0] v, input logic [8:0] m);
      logic [11:0] r;
      logic [11:0] lim;
      r = {3'b000, v};
      for (int k = 3; k >= 0; k--) begin
         lim = 12'(m) << k;
         if (r >= lim) begin
            r = r - lim;
         end
      end
      return r[8:0];
   endfunction

   // Fit a read address to the store index width
   function automatic logic [ADDR_W-1:0] read_index(input logic [RADDR_W-1:0] a);
      logic [31:0] t;
      t = 32'(a);
      return t[ADDR_W-1:0];
   endfunction

endpackage

[sv/pfxs_frame_ram.sv]
module pfxs_frame_ram (
   input  logic                      clock,
   input  pfxs_pkg::pfxs_wr_type     wr,
   input  logic [pfxs_pkg::ADDR_W-1:0] raddr_a,
   input  logic [pfxs_pkg::ADDR_W-1:0] raddr_b,
   output logic [7:0]                rdata_a,
   output logic [7:0]                rdata_b
);
   import pfxs_pkg::*;

   logic [7:0] frame_mem_ff [STORE_BYTES];
   logic [7:0] rdata_a_ff;
   logic [7:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         frame_mem_ff[wr.addr] <= wr.data;
      end
      rdata_a_ff <= frame_mem_ff[raddr_a];
      rdata_b_ff <= frame_mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

[sv/pfxs_ctrl.sv]
module pfxs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  pfxs_pkg::pfxs_req_type      req,
   input  logic [pfxs_pkg::MODE_W-1:0] render_mode,
   output logic                        idle,
   output logic                        done,
   input  logic                        take,
   output pfxs_pkg::pfxs_rsp_type      rsp,
   output pfxs_pkg::pfxs_wr_type       wr,
   output logic [pfxs_pkg::ADDR_W-1:0] raddr_a,
   output logic [pfxs_pkg::ADDR_W-1:0] raddr_b,
   input  logic [7:0]                  rdata_a,
   input  logic [7:0]                  rdata_b
);
   import pfxs_pkg::*;

   pfxs_state_type state_ff, state_in;
   pfxs_sweep_type op_ff, op_in;
   logic                init_ff, init_in;
   logic [PAGE_W-1:0]   kp_ff, kp_in;
   logic [COL_W-1:0]    kc_ff, kc_in;
   logic [SROWS_W-1:0]  rows_ff, rows_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic                use_a_ff, use_a_in;
   logic                use_b_ff, use_b_in;
   logic [2:0]          shift_ff, shift_in;
   logic [COL_W-1:0]    x_ff, x_in;
   logic [ROW_W-1:0]    y_ff, y_in;
   logic                wide_ff, wide_in;
   logic                tall_ff, tall_in;
   logic                val_ff, val_in;
   logic                on_ff, on_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic                coll_ff, coll_in;
   logic [7:0]          data_ff, data_in;
   logic                oor_ff, oor_in;
   logic [ADDR_W-1:0]   rd_addr_ff, rd_addr_in;

   // sweep step
   logic [PAGE_W-1:0] dp;
   logic [COL_W-1:0]  dc;
   logic [ADDR_W-1:0] dest;
   logic [7:0]        dp8, skip8, pa8, pb8;
   logic [COL_W:0]    cl_src;
   logic              ua, ub;
   logic [ADDR_W-1:0] src_a, src_b;
   logic              last_col, last_step;
   logic [7:0]        sweep_wdata;

   // draw
   logic [PAGE_W-1:0] dpage;
   logic [2:0]        dbit;
   logic [7:0]        mask;
   logic [ADDR_W-1:0] addr1, addr2;
   logic [COL_W:0]    x1;
   logic              second;
   logic              old_px, on_px, on_use;
   logic [7:0]        new_byte;
   logic [8:0]        xw, yw;
   logic              wide_req, tall_req;

   always_comb begin
      // sweep destination and sources
      dp = (op_ff == SW_DOWN) ? PAGE_W'(SCREEN_PAGES - 1) - kp_ff : kp_ff;
      dc = (op_ff == SW_RIGHT) ? COL_W'(SCREEN_COLUMNS - 1) - kc_ff : kc_ff;
      dest  = frame_addr(dp, dc);
      dp8   = 8'(dp);
      skip8 = {5'b00000, rows_ff[5:3]};
      pa8   = dp8 - skip8;
      pb8   = pa8 - 8'd1;
      cl_src = '0;
      ua = 1'b0;
      ub = 1'b0;
      src_a = dest;
      src_b = dest;
      case (op_ff)
         SW_DOWN: begin
            ua = (dp8 >= skip8);
            ub = (rows_ff[2:0] != 3'd0) && (dp8 > skip8);
            if (ua) begin
               src_a = frame_addr(pa8[PAGE_W-1:0], dc);
            end
            if (ub) begin
               src_b = frame_addr(pb8[PAGE_W-1:0], dc);
            end
         end
         SW_LEFT: begin
            cl_src = {1'b0, dc} + (COL_W+1)'(SCROLL_COLS);
            ua = (cl_src < (COL_W+1)'(SCREEN_COLUMNS));
            if (ua) begin
               src_a = frame_addr(dp, cl_src[COL_W-1:0]);
            end
         end
         SW_RIGHT: begin
            cl_src = {1'b0, dc} - (COL_W+1)'(SCROLL_COLS);
            ua = (dc >= COL_W'(SCROLL_COLS));
            if (ua) begin
               src_a = frame_addr(dp, cl_src[COL_W-1:0]);
            end
         end
         default: begin
            ua = 1'b0;
         end
      endcase
      last_col  = (kc_ff == COL_W'(SCREEN_COLUMNS - 1));
      last_step = last_col && (kp_ff == PAGE_W'(SCREEN_PAGES - 1));

      // merge the two source bytes of a sweep step
      sweep_wdata = (use_a_ff ? (rdata_a << shift_ff) : 8'd0)
                  | (use_b_ff ? (rdata_b >> (4'd8 - {1'b0, shift_ff})) : 8'd0);

      // draw rectangle
      dpage  = y_ff[ROW_W-1:3];
      dbit   = y_ff[2:0];
      mask   = tall_ff ? (8'b0000_0011 << dbit) : (8'b0000_0001 << dbit);
      addr1  = frame_addr(dpage, x_ff);
      x1     = {1'b0, x_ff} + (COL_W+1)'(1);
      second = wide_ff && (x1 < (COL_W+1)'(SCREEN_COLUMNS));
      addr2  = frame_addr(dpage, x1[COL_W-1:0]);
      old_px = rdata_a[dbit];
      on_px  = old_px ^ val_ff;
      on_use = (state_ff == ST_DRAW_WR) ? on_px : on_ff;
      new_byte = on_use ? (rdata_a | mask) : (rdata_a & ~mask);

      // scaled corner of a new draw
      wide_req = (render_mode == MODE_LORES) || (render_mode == MODE_HIRES);
      tall_req = (render_mode == MODE_LORES);
      xw = wrap_coord(wide_req ? {req.pixel_x, 1'b0} : {1'b0, req.pixel_x},
                      9'(SCREEN_COLUMNS));
      yw = wrap_coord(tall_req ? {req.pixel_y, 1'b0} : {1'b0, req.pixel_y},
                      9'(SCREEN_ROWS));
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      init_in      = init_ff;
      kp_in        = kp_ff;
      kc_in        = kc_ff;
      rows_in      = rows_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      use_a_in     = use_a_ff;
      use_b_in     = use_b_ff;
      shift_in     = shift_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      wide_in      = wide_ff;
      tall_in      = tall_ff;
      val_in       = val_ff;
      on_in        = on_ff;
      act_in       = act_ff;
      coll_in      = coll_ff;
      data_in      = data_ff;
      oor_in       = oor_ff;
      rd_addr_in   = rd_addr_ff;
      idle         = 1'b0;
      done         = 1'b0;
      raddr_a      = '0;
      raddr_b      = '0;
      wr           = '{en: 1'b0, addr: '0, data: 8'd0};

      // write back the step issued last cycle
      if (pend_ff) begin
         wr = '{en: 1'b1, addr: pend_addr_ff, data: sweep_wdata};
      end

      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               act_in     = req.action;
               coll_in    = 1'b0;
               data_in    = 8'd0;
               kp_in      = '0;
               kc_in      = '0;
               rows_in    = req.scroll_rows;
               x_in       = xw[COL_W-1:0];
               y_in       = yw[ROW_W-1:0];
               wide_in    = wide_req;
               tall_in    = tall_req;
               val_in     = req.draw_value;
               rd_addr_in = read_index(req.read_address);
               oor_in     = (32'(req.read_address) >= 32'(STORE_BYTES));
               case (req.action)
                  ACT_DRAW: begin
                     state_in = ST_DRAW_RD;
                  end
                  ACT_DOWN: begin
                     op_in    = SW_DOWN;
                     state_in = ST_SWEEP;
                  end
                  ACT_LEFT: begin
                     op_in    = SW_LEFT;
                     state_in = ST_SWEEP;
                  end
                  ACT_RIGHT: begin
                     op_in    = SW_RIGHT;
                     state_in = ST_SWEEP;
                  end
                  ACT_CLEAR: begin
                     op_in    = SW_CLEAR;
                     state_in = ST_SWEEP;
                  end
                  ACT_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            raddr_a      = src_a;
            raddr_b      = src_b;
            pend_in      = 1'b1;
            pend_addr_in = dest;
            use_a_in     = ua;
            use_b_in     = ub;
            shift_in     = (op_ff == SW_DOWN) ? rows_ff[2:0] : 3'd0;
            if (last_col) begin
               kc_in = '0;
               kp_in = kp_ff + PAGE_W'(1);
            end else begin
               kc_in = kc_ff + COL_W'(1);
            end
            if (last_step) begin
               init_in  = 1'b0;
               state_in = init_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_DRAW_RD: begin
            raddr_a  = addr1;
            state_in = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            wr      = '{en: 1'b1, addr: addr1, data: new_byte};
            coll_in = old_px & val_ff;
            on_in   = on_px;
            if (second) begin
               raddr_a  = addr2;
               state_in = ST_DRAW_WR2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DRAW_WR2: begin
            wr       = '{en: 1'b1, addr: addr2, data: new_byte};
            state_in = ST_DONE;
         end
         ST_READ: begin
            raddr_a  = rd_addr_ff;
            state_in = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            data_in  = oor_ff ? 8'd0 : rdata_a;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            done = 1'b1;
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp = '{collision: coll_ff, read_data: data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff   <= SW_CLEAR;
         init_ff <= 1'b1;
         kp_ff   <= '0;
         kc_ff   <= '0;
         pend_ff <= 1'b0;
      end else begin
         op_ff   <= op_in;
         init_ff <= init_in;
         kp_ff   <= kp_in;
         kc_ff   <= kc_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff      <= rows_in;
      pend_addr_ff <= pend_addr_in;
      use_a_ff     <= use_a_in;
      use_b_ff     <= use_b_in;
      shift_ff     <= shift_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      wide_ff      <= wide_in;
      tall_ff      <= tall_in;
      val_ff       <= val_in;
      on_ff        <= on_in;
      act_ff       <= act_in;
      coll_ff      <= coll_in;
      data_ff      <= data_in;
      oor_ff       <= oor_in;
      rd_addr_ff   <= rd_addr_in;
   end

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("item started while busy");

   a_sweep_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && pend_ff) |->
         (pend_addr_ff != raddr_a && pend_addr_ff != raddr_b))
      else $error("sweep read hits the byte being written back");

   a_wr2_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAW_WR2 |-> $past(state_ff) == ST_DRAW_WR)
      else $error("second draw column without first");

   a_coll_draw: assert property (@(posedge clock) disable iff (reset)
      (done && rsp.collision) |-> act_ff == ACT_DRAW)
      else $error("collision reported for a non-draw item");
`endif

endmodule

[sv/paged_framebuffer_xor_scroll.sv]
// Paged 128x64 monochrome frame buffer with XOR pixel draw and scrolling.
// Request channel (req_valid / req_stall): one item carries an action and its
// operands. Draw XORs a scaled pixel rectangle (mode register csr_: 2x2, 2x1,
// 1x1) and reports a collision; scroll down/left/right and clear walk the
// whole store one byte per cycle; read returns one stored byte.
// Result channel (rsp_valid / rsp_stall): exactly one item per request, in
// order, held in an output register until taken.
// A draw reads and rewrites its byte, and the next column's byte as well when
// two columns wide; a read fetches one byte; scroll and clear sweep all
// STORE_BYTES bytes (1024 at 128x8); unused actions go straight to done. One
// item is in work at a time; the sweep rate is set by the single write port
// of the frame memory, one byte per cycle.
// req_stall is high whenever an item is in work. A finished item waits in
// the engine while rsp_stall holds a previous item in the output register.
// Reset (synchronous, active high) clears the mode register to 2x2 and runs
// a clearing pass over all STORE_BYTES bytes of the frame memory (1024 at
// 128x8), during which req_stall stays high; csr writes are taken as ever.
module paged_framebuffer_xor_scroll (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pfxs_pkg::ACTION_W-1:0]  req_action,
   input  logic [pfxs_pkg::COORD_W-1:0]   req_pixel_x,
   input  logic [pfxs_pkg::COORD_W-1:0]   req_pixel_y,
   input  logic                           req_draw_value,
   input  logic [pfxs_pkg::SROWS_W-1:0]   req_scroll_rows,
   input  logic [pfxs_pkg::RADDR_W-1:0]   req_read_address,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_collision,
   output logic [7:0]                     rsp_read_data,
   input  logic                           csr_wr_en,
   input  logic [pfxs_pkg::MODE_W-1:0]    csr_wr_data
);
   import pfxs_pkg::*;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_collision_ff, rsp_collision_in;
   logic [7:0]        rsp_read_data_ff, rsp_read_data_in;

   pfxs_req_type      req;
   pfxs_rsp_type      eng_rsp;
   pfxs_wr_type       wr;
   logic              start;
   logic              idle;
   logic              done;
   logic              take;
   logic [ADDR_W-1:0] raddr_a;
   logic [ADDR_W-1:0] raddr_b;
   logic [7:0]        rdata_a;
   logic [7:0]        rdata_b;

   // gather the request fields into one item
   assign req = '{action:       req_action,
                  pixel_x:      req_pixel_x,
                  pixel_y:      req_pixel_y,
                  draw_value:   req_draw_value,
                  scroll_rows:  req_scroll_rows,
                  read_address: req_read_address};

   // accept only when the engine has nothing in work
   assign req_stall = ~idle;
   assign start     = req_valid & ~req_stall;

   // move a finished item into the output register once it is free
   assign take = done & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      mode_in          = csr_wr_en ? csr_wr_data : mode_ff;
      rsp_valid_in     = take | (rsp_valid_ff & rsp_stall);
      rsp_collision_in = take ? eng_rsp.collision : rsp_collision_ff;
      rsp_read_data_in = take ? eng_rsp.read_data : rsp_read_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_LORES;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload: hold while stalled, no reset needed
   always_ff @(posedge clock) begin
      rsp_collision_ff <= rsp_collision_in;
      rsp_read_data_ff <= rsp_read_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_collision = rsp_collision_ff;
   assign rsp_read_data = rsp_read_data_ff;

   pfxs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req),
      .render_mode (mode_ff),
      .idle        (idle),
      .done        (done),
      .take        (take),
      .rsp         (eng_rsp),
      .wr          (wr),
      .raddr_a     (raddr_a),
      .raddr_b     (raddr_b),
      .rdata_a     (rdata_a),
      .rdata_b     (rdata_b)
   );

   pfxs_frame_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

endmodule
